// ===== src/cross_sharpen_3x3_stream_core_defines.svh =====
// ---------------------------------------------------------------------------
// cross_sharpen_3x3_stream_core_defines
// assertion macros shared by the cross sharpen core
// ---------------------------------------------------------------------------
`ifndef CROSS_SHARPEN_3X3_STREAM_CORE_DEFINES_SVH
`define CROSS_SHARPEN_3X3_STREAM_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define XSH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/xsh_pkg.sv =====
// ---------------------------------------------------------------------------
// xsh_pkg
// shared widths, reset values, register indexes and types of the cross sharpen core
// ---------------------------------------------------------------------------
package xsh_pkg;

	localparam int SAMPLE_W          = 8;
	localparam int ROW_BYTES_W       = 14;
	localparam int CH_W              = 3;
	localparam int CFG_INDEX_W       = 1;
	localparam int CFG_DATA_W        = 14;

	localparam int MAX_ROW_BYTES_DEF = 8192;
	localparam int MAX_CHANNELS_DEF  = 4;

	localparam int MIN_ROW_BYTES     = 3;
	localparam int SHARP_GAIN        = 5;

	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 14'd1920;
	localparam logic [CH_W-1:0]        CHANNELS_RST  = 3'd3;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS  = 1'b1;

	// per-cycle requests from the control pipeline to the row stores
	typedef struct packed {
		logic acc;   // sample transfer: read and overwrite middle row
		logic u_re;  // read upper row at the centre column
		logic u_we;  // write centre back into upper row
	} xsh_mem_ctl_t;

endpackage

// ===== src/xsh_kernel.sv =====
// ---------------------------------------------------------------------------
// xsh_kernel
// cross kernel arithmetic: 5*centre minus four neighbours, zero at a border, clamped to 0..255
// ---------------------------------------------------------------------------
module xsh_kernel (
	input  logic [xsh_pkg::SAMPLE_W-1:0] centre,
	input  logic [xsh_pkg::SAMPLE_W-1:0] left,
	input  logic [xsh_pkg::SAMPLE_W-1:0] right,
	input  logic [xsh_pkg::SAMPLE_W-1:0] up,
	input  logic [xsh_pkg::SAMPLE_W-1:0] down,
	input  logic                         border,
	output logic [xsh_pkg::SAMPLE_W-1:0] result
);

	localparam int SW  = xsh_pkg::SAMPLE_W;
	localparam int NW  = SW + 2;  // sum of four samples
	localparam int GW  = SW + 3;  // gain times centre
	localparam int AW  = SW + 4;  // signed difference

	logic [NW-1:0]        nbr_sum;
	logic [GW-1:0]        gained;
	logic signed [AW-1:0] diff;

	always_comb begin
		nbr_sum = NW'(left) + NW'(right) + NW'(up) + NW'(down);
		gained  = GW'(centre) * GW'(xsh_pkg::SHARP_GAIN);
		diff    = $signed(AW'(gained)) - $signed(AW'(nbr_sum));
		if (border) begin
			result = '0;
		end else if (diff < 0) begin
			result = '0;
		end else if (diff > $signed(AW'({SW{1'b1}}))) begin
			result = {SW{1'b1}};
		end else begin
			result = diff[SW-1:0];
		end
	end

endmodule

// ===== src/xsh_row_store.sv =====
// ---------------------------------------------------------------------------
// xsh_row_store
// middle and upper row memories, registered reads, upper row forwarding
// ---------------------------------------------------------------------------
module xsh_row_store #(
	parameter int MAX_ROW_BYTES = xsh_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  xsh_pkg::xsh_mem_ctl_t                ctl,
	input  logic [$clog2(MAX_ROW_BYTES)-1:0]     col,
	input  logic [xsh_pkg::SAMPLE_W-1:0]         sample,
	input  logic [$clog2(MAX_ROW_BYTES)-1:0]     rd_k,
	input  logic [$clog2(MAX_ROW_BYTES)-1:0]     wr_k,
	input  logic [xsh_pkg::SAMPLE_W-1:0]         centre,
	output logic [xsh_pkg::SAMPLE_W-1:0]         mid,
	output logic [xsh_pkg::SAMPLE_W-1:0]         up
);

	localparam int AW = $clog2(MAX_ROW_BYTES);
	localparam int SW = xsh_pkg::SAMPLE_W;

	logic [SW-1:0] mid_mem [MAX_ROW_BYTES];
	logic [SW-1:0] up_mem  [MAX_ROW_BYTES];

	logic [SW-1:0] mid_q;
	logic [SW-1:0] up_rd_q;
	logic [SW-1:0] fwd_data_q;
	logic          fwd_q;

	// middle row: read the old value, then the new sample takes its place
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			mid_mem[col] <= sample;
			mid_q        <= mid_mem[col];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.u_we) begin
			up_mem[wr_k] <= centre;
		end
		if (ctl.u_re) begin
			up_rd_q <= up_mem[rd_k];
		end
		if (ctl.acc) begin
			fwd_data_q <= centre;
		end
	end

	// same entry written and read in one cycle: the write wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctl.acc) begin
			fwd_q <= ctl.u_we && ctl.u_re && (wr_k == rd_k);
		end
	end

	assign mid = mid_q;
	assign up  = fwd_q ? fwd_data_q : up_rd_q;

endmodule

// ===== src/cross_sharpen_3x3_stream_core.sv =====
// ---------------------------------------------------------------------------
// cross_sharpen_3x3_stream_core
// streaming 3x3 cross-kernel sharpen over interleaved 8-bit samples
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  input    | in_valid / in_stall     | pixel_sample, frame_start
//  output   | out_valid / out_stall   | sharp_sample, border_flag
//  config   | cfg_wr_en               | cfg_index, cfg_data
//
//  one sample per clock while in_stall is low; a result passes the s1 stage,
//  which takes the registered reads of the row memories, then the output register
//  reset clears counters, window and config; row memories are not cleared
//  out_stall holds the output register, then the s1 stage, then in_stall
//  non-emitting samples pass s1 even while the output is stalled
// ---------------------------------------------------------------------------
`include "cross_sharpen_3x3_stream_core_defines.svh"

module cross_sharpen_3x3_stream_core #(
	parameter int MAX_ROW_BYTES = xsh_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_CHANNELS  = xsh_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [xsh_pkg::SAMPLE_W-1:0]        pixel_sample,
	input  logic                                frame_start,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [xsh_pkg::SAMPLE_W-1:0]        sharp_sample,
	output logic                                border_flag,

	input  logic                                cfg_wr_en,
	input  logic [xsh_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [xsh_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW    = xsh_pkg::SAMPLE_W;
	localparam int RBW   = xsh_pkg::ROW_BYTES_W;
	localparam int CHQW  = xsh_pkg::CH_W;
	localparam int AW    = $clog2(MAX_ROW_BYTES);
	localparam int WW    = AW + 1;
	localparam int CMPW  = (WW > RBW) ? WW : RBW;
	localparam int CHW   = $clog2(MAX_CHANNELS + 1);
	localparam int CHW1  = CHW + 1;
	localparam int WIN_D = 2 * MAX_CHANNELS;
	localparam int WIX   = $clog2(WIN_D);
	localparam int DLIX  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// configuration
	logic [RBW-1:0]  row_bytes_q;
	logic [CHQW-1:0] channels_q;
	logic [CMPW-1:0] rb_ext;
	logic [CMPW-1:0] rb_clamp;
	logic [WW-1:0]   w_eff;
	logic [CHW-1:0]  ch_eff;

	// position state
	logic [AW-1:0]   col_q;
	logic [1:0]      rows_q;

	// input side
	logic            in_acc;
	logic [AW-1:0]   col_raw;
	logic [1:0]      rows0;
	logic [AW-1:0]   col0;
	logic [AW-1:0]   ch_ext;
	logic            c_ge;
	logic [AW-1:0]   k0;
	logic            emit0;
	logic            border0;
	logic            last0;
	logic [SW-1:0]   dl_q [MAX_CHANNELS];
	logic [SW-1:0]   down0;

	// s1 stage
	logic            s1_valid_s1;
	logic            s1_emit_s1;
	logic            s1_border_s1;
	logic            s1_uwe_s1;
	logic [AW-1:0]   s1_k_s1;
	logic [SW-1:0]   s1_down_s1;
	logic            s1_adv;
	logic            out_ready;

	// window of middle row reads
	logic [SW-1:0]   win_q [WIN_D];
	logic [SW-1:0]   mid;
	logic [SW-1:0]   up;
	logic [SW-1:0]   centre;
	logic [SW-1:0]   left;
	logic [CHW1-1:0] left_idx;
	logic [SW-1:0]   result;

	// output register
	logic            out_valid_q;
	logic [SW-1:0]   sharp_q;
	logic            border_q;

	xsh_pkg::xsh_mem_ctl_t mem_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= xsh_pkg::ROW_BYTES_RST;
			channels_q  <= xsh_pkg::CHANNELS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				xsh_pkg::REG_ROW_BYTES: row_bytes_q <= RBW'(cfg_data);
				xsh_pkg::REG_CHANNELS:  channels_q  <= cfg_data[CHQW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rb_ext = CMPW'(row_bytes_q);
		if (rb_ext < CMPW'(xsh_pkg::MIN_ROW_BYTES)) begin
			rb_clamp = CMPW'(xsh_pkg::MIN_ROW_BYTES);
		end else if (rb_ext > CMPW'(MAX_ROW_BYTES)) begin
			rb_clamp = CMPW'(MAX_ROW_BYTES);
		end else begin
			rb_clamp = rb_ext;
		end
		w_eff = WW'(rb_clamp);

		if (channels_q == '0) begin
			ch_eff = CHW'(1);
		end else if (channels_q > CHQW'(MAX_CHANNELS)) begin
			ch_eff = CHW'(MAX_CHANNELS);
		end else begin
			ch_eff = CHW'(channels_q);
		end
	end

	// handshake
	assign out_ready = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid_s1 && (!s1_emit_s1 || out_ready);
	assign in_stall  = s1_valid_s1 && !s1_adv;
	assign in_acc    = in_valid && !in_stall;

	// column and row bookkeeping for the incoming sample
	always_comb begin
		col_raw = frame_start ? '0 : col_q;
		rows0   = frame_start ? 2'd0 : rows_q;
		col0    = ({1'b0, col_raw} >= w_eff) ? '0 : col_raw;
		ch_ext  = AW'(ch_eff);
		c_ge    = col0 >= ch_ext;
		k0      = col0 - ch_ext;
		last0   = (WW'(col0) + WW'(1)) >= w_eff;
		if (c_ge) begin
			emit0   = rows0 != 2'd0;
			border0 = (rows0 != 2'd2) || (k0 < ch_ext);
		end else begin
			// right border of the row two above
			emit0   = rows0 == 2'd2;
			border0 = 1'b1;
		end
		// lower neighbour is the sample one pixel back in this row
		down0 = dl_q[DLIX'(ch_eff - CHW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= 2'd0;
		end else if (in_acc) begin
			col_q <= last0 ? '0 : col0 + AW'(1);
			if (last0 && rows0 != 2'd2) begin
				rows_q <= rows0 + 2'd1;
			end else begin
				rows_q <= rows0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dl_q[0] <= pixel_sample;
			for (int i = 1; i < MAX_CHANNELS; i++) begin
				dl_q[i] <= dl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_emit_s1   <= emit0;
			s1_border_s1 <= border0;
			s1_uwe_s1    <= c_ge;
			s1_k_s1      <= k0;
			s1_down_s1   <= down0;
		end
	end

	always_comb begin
		mem_ctl.acc  = in_acc;
		mem_ctl.u_re = in_acc && c_ge;
		mem_ctl.u_we = s1_adv && s1_uwe_s1;
	end

	xsh_row_store #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_rows (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.col    (col0),
		.sample (pixel_sample),
		.rd_k   (k0),
		.wr_k   (s1_k_s1),
		.centre (centre),
		.mid    (mid),
		.up     (up)
	);

	// centre sits one pixel back in the window, left neighbour two pixels back
	always_comb begin
		left_idx = {ch_eff, 1'b0} - CHW1'(1);
		centre   = win_q[WIX'(ch_eff - CHW'(1))];
		left     = win_q[WIX'(left_idx)];
	end

	xsh_kernel u_kernel (
		.centre (centre),
		.left   (left),
		.right  (mid),
		.up     (up),
		.down   (s1_down_s1),
		.border (s1_border_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_D; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= mid;
			for (int i = 1; i < WIN_D; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_emit_s1) begin
			sharp_q  <= result;
			border_q <= s1_border_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign sharp_sample = sharp_q;
	assign border_flag  = border_q;

	`XSH_ASSERT_NOW(a_empty_s1_takes_input, clk, arst_n, !s1_valid_s1, !in_stall, "input stalled with empty s1 stage")
	`XSH_ASSERT_NEXT(a_emit_reaches_output, clk, arst_n, s1_adv && s1_emit_s1, out_valid, "emitting sample lost before output register")
	`XSH_ASSERT_NOW(a_border_is_zero, clk, arst_n, out_valid && border_flag, sharp_sample == '0, "border result carries nonzero sample")
	`XSH_ASSERT_NOW(a_rows_saturate, clk, arst_n, 1'b1, rows_q != 2'd3, "row count passed saturation")

endmodule
